// ----- rtl/core/cached_palette_nearest_match_core_macros.svh -----
// assertion macros for the cached palette nearest match core
`ifndef CACHED_PALETTE_NEAREST_MATCH_CORE_MACROS_SVH
`define CACHED_PALETTE_NEAREST_MATCH_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPNM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CPNM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cpnm_pkg.sv -----
// types and constants shared by the cached palette nearest match core
package cpnm_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_INVAL  = 2'd2;

    localparam int CFG_W   = 9;
    localparam int DIST_W  = 19;
    localparam int TERM_W  = 18;
    localparam int ALPHA_SHIFT = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] palette_tag;
        logic [7:0]  entry_number;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_in_req;

    typedef struct packed {
        logic [7:0] palette_index;
        logic       cache_hit;
    } t_out_rsp;

    typedef struct packed {
        logic [31:0] colour;
        logic [7:0]  result;
        logic [31:0] owner;
    } t_cache_line;

endpackage

// ----- rtl/core/cached_palette_nearest_match_core.sv -----
// nearest palette colour search behind a direct-mapped result cache
//
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_ready     cpnm_pkg::t_in_req
// out      out  o_out_valid / i_out_ready   cpnm_pkg::t_out_rsp
// cfg      in   i_cfg_valid / o_cfg_ready   palette_size, 9 bits
//
// a load writes the palette entry without leaving the idle state; a lookup hit goes through the check and done states
// a lookup miss scans the palette entries, one palette read a cycle
// invalidate walks every cache line, one cache line read per cycle
// after reset a clearing pass empties the cache; no requests
// are taken then, configuration writes always are
// results wait in an output register; a full register stalls only the final step
module cached_palette_nearest_match_core #(
    parameter int PALETTE_DEPTH = 256,
    parameter int CACHE_LINES   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cpnm_pkg::t_in_req    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cpnm_pkg::t_out_rsp   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [8:0]           i_cfg_data
);
    import cpnm_pkg::*;

    localparam int PW = $clog2(PALETTE_DEPTH);
    localparam int LW = $clog2(CACHE_LINES);
    localparam logic [CFG_W-1:0] DEPTH_N = CFG_W'(PALETTE_DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_INVAL = 3'd5;

    logic [31:0]       pmem [PALETTE_DEPTH];
    t_cache_line       cmem [CACHE_LINES];

    logic [2:0]        r_state;
    logic [CFG_W-1:0]  r_palette_size;
    logic [LW:0]       r_cnt;
    logic              r_inv_pend;
    logic [LW-1:0]     r_inv_addr;
    logic [31:0]       r_tag;
    logic [31:0]       r_pixel;
    logic [LW-1:0]     r_line;
    logic [7:0]        r_best;
    logic              r_hit;
    logic              r_fill;
    logic [CFG_W-1:0]  r_issue_cnt;
    logic              r_p_vld;
    logic [7:0]        r_p_idx;
    logic [31:0]       r_p_rdata;
    logic              r_s_vld;
    logic [7:0]        r_s_idx;
    logic signed [TERM_W-1:0] r_s_t0, r_s_t1, r_s_t2, r_s_t3;
    logic              r_stop;
    logic              r_have;
    logic signed [DIST_W-1:0] r_best_d;
    t_cache_line       r_c_rdata;
    logic              r_out_valid;
    t_out_rsp          r_out_data;

    logic [31:0]       w_in_pixel;
    logic [LW-1:0]     w_in_line;
    logic              w_accept;
    logic [CFG_W-1:0]  w_n;
    logic              w_issue;
    logic              w_out_free;
    logic              w_hit;
    logic              w_scan_end;
    logic              c_we;
    logic [LW-1:0]     c_waddr;
    t_cache_line       c_wdata;
    logic [LW-1:0]     c_raddr;
    logic              p_we;
    logic signed [8:0] w_dr, w_dg, w_db, w_da;
    logic signed [TERM_W-1:0] w_sq_r, w_sq_g, w_sq_b, w_sq_a;
    logic signed [DIST_W-1:0] w_d;

    assign w_in_pixel = {i_in_data.alpha, i_in_data.red, i_in_data.green, i_in_data.blue};
    assign w_in_line  = w_in_pixel[LW-1:0] ^ i_in_data.palette_tag[LW-1:0];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n        = (r_palette_size > DEPTH_N) ? DEPTH_N : r_palette_size;
    assign w_issue    = (r_state == S_SCAN) && !r_stop && (r_issue_cnt < w_n);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_hit      = (r_tag != 32'd0) && (r_c_rdata.owner == r_tag)
                        && (r_c_rdata.colour == r_pixel);
    assign w_scan_end = r_stop || ((r_issue_cnt == w_n) && !r_p_vld && !r_s_vld);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign p_we = w_accept && (i_in_data.command == CMD_LOAD)
                  && ({1'b0, i_in_data.entry_number} < DEPTH_N);

    // palette store
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            pmem[i_in_data.entry_number[PW-1:0]] <= w_in_pixel;
        end
        r_p_rdata <= pmem[r_issue_cnt[PW-1:0]];
    end

    // cache write and read port selection
    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_line;
        c_wdata = '0;
        c_raddr = r_cnt[LW-1:0];
        case (r_state)
            S_CLEAR: begin
                c_we    = !r_cnt[LW];
                c_waddr = r_cnt[LW-1:0];
            end
            S_IDLE: begin
                c_raddr = w_in_line;
            end
            S_INVAL: begin
                c_we    = r_inv_pend && (r_c_rdata.owner == r_tag);
                c_waddr = r_inv_addr;
            end
            S_DONE: begin
                c_we    = r_fill && w_out_free;
                c_wdata = '{colour: r_pixel, result: r_best, owner: r_tag};
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    // cache store
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cmem[c_waddr] <= c_wdata;
        end
        r_c_rdata <= cmem[c_raddr];
    end

    // distance terms of the entry just read
    always_comb begin
        w_dr   = $signed({1'b0, r_p_rdata[23:16]}) - $signed({1'b0, r_pixel[23:16]});
        w_dg   = $signed({1'b0, r_p_rdata[15:8]})  - $signed({1'b0, r_pixel[15:8]});
        w_db   = $signed({1'b0, r_p_rdata[7:0]})   - $signed({1'b0, r_pixel[7:0]});
        w_da   = $signed({1'b0, r_p_rdata[31:24]}) - $signed({1'b0, r_pixel[31:24]});
        w_sq_r = TERM_W'(w_dr) * TERM_W'(w_dr);
        w_sq_g = TERM_W'(w_dg) * TERM_W'(w_dg);
        w_sq_b = TERM_W'(w_db) * TERM_W'(w_db);
        w_sq_a = TERM_W'(w_da) * TERM_W'(w_da);
    end

    assign w_d = DIST_W'(r_s_t0) + DIST_W'(r_s_t1) + DIST_W'(r_s_t2) + DIST_W'(r_s_t3);

    // search datapath
    always_ff @(posedge i_clk) begin
        r_p_idx <= r_issue_cnt[7:0];
        r_s_idx <= r_p_idx;
        if (r_pixel[31:24] != 8'd0) begin
            r_s_t0 <= w_sq_r;
            r_s_t1 <= w_sq_g;
            r_s_t2 <= w_sq_b;
            r_s_t3 <= w_sq_a >>> ALPHA_SHIFT;
        end else begin
            r_s_t0 <= TERM_W'(w_dr);
            r_s_t1 <= TERM_W'(w_dg);
            r_s_t2 <= TERM_W'(w_db);
            r_s_t3 <= w_sq_a;
        end
        if (w_accept) begin
            r_tag   <= i_in_data.palette_tag;
            r_pixel <= w_in_pixel;
            r_line  <= w_in_line;
        end
        if (r_state == S_INVAL) begin
            r_inv_addr <= r_cnt[LW-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_palette_size <= DEPTH_N;
            r_cnt          <= '0;
            r_inv_pend     <= 1'b0;
            r_issue_cnt    <= '0;
            r_p_vld        <= 1'b0;
            r_s_vld        <= 1'b0;
            r_stop         <= 1'b0;
            r_have         <= 1'b0;
            r_best         <= '0;
            r_best_d       <= '0;
            r_hit          <= 1'b0;
            r_fill         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_palette_size <= i_cfg_data;
            end

            r_p_vld    <= w_issue;
            r_s_vld    <= (r_state == S_SCAN) && r_p_vld;
            r_inv_pend <= (r_state == S_INVAL) && !r_cnt[LW];
            if (w_issue) begin
                r_issue_cnt <= r_issue_cnt + 1'b1;
            end

            if ((r_state == S_SCAN) && r_s_vld && !r_stop) begin
                if (!r_have || (w_d < r_best_d)) begin
                    r_best   <= r_s_idx;
                    r_best_d <= w_d;
                end
                r_have <= 1'b1;
                if (w_d == '0) begin
                    r_stop <= 1'b1;
                end
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= '{palette_index: r_best, cache_hit: r_hit};
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_cnt[LW]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in_data.command)
                            CMD_LOOKUP: begin
                                r_state <= S_CHECK;
                            end
                            CMD_INVAL: begin
                                r_cnt   <= '0;
                                r_state <= S_INVAL;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (w_hit) begin
                        r_best  <= r_c_rdata.result;
                        r_hit   <= 1'b1;
                        r_fill  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_best      <= '0;
                        r_hit       <= 1'b0;
                        r_fill      <= 1'b1;
                        r_issue_cnt <= '0;
                        r_have      <= 1'b0;
                        r_stop      <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_INVAL: begin
                    if (r_cnt[LW]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/cpnm_checker.sv -----
// port-level checks for the cached palette nearest match core, with its bind
`include "cached_palette_nearest_match_core_macros.svh"

module cpnm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cpnm_pkg::t_in_req  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready
);
    import cpnm_pkg::*;

    `CPNM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `CPNM_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.command == CMD_LOOKUP), !o_in_ready, "request taken during lookup")
    `CPNM_ASSERT_NEXT(a_inval_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.command == CMD_INVAL), !o_in_ready, "request taken during invalidate")
    `CPNM_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_data.command == CMD_LOAD), o_in_ready, "load did not complete in one cycle")

endmodule

bind cached_palette_nearest_match_core cpnm_checker u_cpnm_checker (.*);
